>>> design/tlcr_pkg.sv
// tlcr_pkg: types, codes and keyword tables for the text line command receiver
// no dependencies; imported by every module of the block

package tlcr_pkg;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_ISSUE = 2'd2;

    localparam logic [2:0] REPLY_NONE    = 3'd0;
    localparam logic [2:0] REPLY_PONG    = 3'd1;
    localparam logic [2:0] REPLY_OK      = 3'd2;
    localparam logic [2:0] REPLY_UNKNOWN = 3'd3;
    localparam logic [2:0] REPLY_ERROR   = 3'd4;

    localparam logic [1:0] ACK_NONE    = 2'd0;
    localparam logic [1:0] ACK_DONE    = 2'd1;
    localparam logic [1:0] ACK_TIMEOUT = 2'd2;

    localparam logic CFG_ASK_TIMEOUT     = 1'b0;
    localparam logic CFG_LED_ACTIVE_HIGH = 1'b1;

    localparam logic [1:0] PHASE_TYPE    = 2'd0;
    localparam logic [1:0] PHASE_ID      = 2'd1;
    localparam logic [1:0] PHASE_PAYLOAD = 2'd2;

    localparam logic [1:0] KW_PING   = 2'd0;
    localparam logic [1:0] KW_PONG   = 2'd1;
    localparam logic [1:0] KW_CMD    = 2'd2;
    localparam logic [1:0] KW_STATUS = 2'd3;

    localparam logic PAY_LED_ON  = 1'b0;
    localparam logic PAY_LED_OFF = 1'b1;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;

    localparam logic [7:0] TYPE_CHARS [0:3][0:7] = '{
        '{"P", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"C", "M", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "A", "T", "U", "S", 8'h00, 8'h00}
    };
    localparam logic [2:0] TYPE_LENS [0:3] = '{3'd4, 3'd4, 3'd3, 3'd6};

    localparam logic [7:0] PAY_CHARS [0:1][0:7] = '{
        '{"L", "E", "D", "_", "O", "N", 8'h00, 8'h00},
        '{"L", "E", "D", "_", "O", "F", "F", 8'h00}
    };
    localparam logic [3:0] PAY_LENS [0:1] = '{4'd6, 4'd7};

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  reply;
        logic [15:0] reply_id;
        logic        led_level;
        logic [1:0]  ack_event;
        logic [15:0] ack_id;
        logic [15:0] command_id;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  reply;
        logic [15:0] reply_id;
        logic        led_write;
        logic        led_value;
        logic        status_seen;
        logic [15:0] status_id;
    } t_line_res;

    typedef struct packed {
        logic [1:0]  ack_event;
        logic [15:0] ack_id;
        logic [15:0] command_id;
    } t_ack_res;

    function automatic logic type_char_hit(input logic [1:0] k, input logic [2:0] pos,
                                           input logic [7:0] c);
        return (pos < TYPE_LENS[k]) && (TYPE_CHARS[k][pos] == c);
    endfunction

    function automatic logic pay_char_hit(input logic k, input logic [3:0] pos,
                                          input logic [7:0] c);
        return (pos < PAY_LENS[k]) && (PAY_CHARS[k][pos[2:0]] == c);
    endfunction

endpackage

>>> design/tlcr_line_parser.sv
// tlcr_line_parser: running line state, keyword matchers and id accumulator
// decodes the finished line at newline; depends on tlcr_pkg

module tlcr_line_parser import tlcr_pkg::*; #(
    parameter int MAX_LINE_CHARS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic [7:0] i_byte,
    output t_line_res o_res
);

    localparam int LCW = $clog2(MAX_LINE_CHARS + 1);

    logic [LCW-1:0] r_line_count, n_line_count;
    logic [1:0]     r_field_phase, n_field_phase;
    logic [3:0]     r_type_match, n_type_match;
    logic [2:0]     r_type_pos, n_type_pos;
    logic [1:0]     r_pay_match, n_pay_match;
    logic [3:0]     r_pay_pos, n_pay_pos;
    logic [15:0]    r_id_value, n_id_value;
    logic           r_id_empty, n_id_empty;
    logic           r_id_bad, n_id_bad;
    logic           r_content, n_content;
    logic           r_space, n_space;
    logic           r_badcs, n_badcs;

    logic is_ws, is_digit, is_good, do_clear;

    always_comb begin
        is_ws    = (i_byte == CHAR_SPACE) || (i_byte == CHAR_TAB) ||
                   (i_byte == CHAR_VT) || (i_byte == CHAR_FF);
        is_digit = (i_byte >= "0") && (i_byte <= "9");
        is_good  = ((i_byte >= "A") && (i_byte <= "Z")) || is_digit ||
                   (i_byte == CHAR_UNDER) || (i_byte == CHAR_COLON);

        n_line_count  = r_line_count;
        n_field_phase = r_field_phase;
        n_type_match  = r_type_match;
        n_type_pos    = r_type_pos;
        n_pay_match   = r_pay_match;
        n_pay_pos     = r_pay_pos;
        n_id_value    = r_id_value;
        n_id_empty    = r_id_empty;
        n_id_bad      = r_id_bad;
        n_content     = r_content;
        n_space       = r_space;
        n_badcs       = r_badcs;
        do_clear      = 1'b0;
        o_res         = '0;

        if (i_en) begin
            if (i_byte == CHAR_LF) begin
                do_clear = 1'b1;
                if (!r_content) begin
                    o_res.reply = REPLY_NONE;
                end else if (r_badcs) begin
                    o_res.reply = REPLY_ERROR;
                end else if (r_field_phase == PHASE_TYPE) begin
                    if (r_type_match[KW_PING] && r_type_pos == TYPE_LENS[KW_PING]) begin
                        o_res.reply = REPLY_PONG;
                    end else if (r_type_match[KW_PONG] &&
                                 r_type_pos == TYPE_LENS[KW_PONG]) begin
                        o_res.reply = REPLY_NONE;
                    end else begin
                        o_res.reply = REPLY_ERROR;
                    end
                end else if (r_field_phase == PHASE_ID || r_id_empty || r_id_bad) begin
                    o_res.reply = REPLY_ERROR;
                end else if (r_type_match[KW_CMD] && r_type_pos == TYPE_LENS[KW_CMD]) begin
                    o_res.reply_id = r_id_value;
                    if (r_pay_match[PAY_LED_ON] && r_pay_pos == PAY_LENS[PAY_LED_ON]) begin
                        o_res.reply     = REPLY_OK;
                        o_res.led_write = 1'b1;
                        o_res.led_value = 1'b1;
                    end else if (r_pay_match[PAY_LED_OFF] &&
                                 r_pay_pos == PAY_LENS[PAY_LED_OFF]) begin
                        o_res.reply     = REPLY_OK;
                        o_res.led_write = 1'b1;
                        o_res.led_value = 1'b0;
                    end else begin
                        o_res.reply = REPLY_UNKNOWN;
                    end
                end else if (r_type_match[KW_STATUS] &&
                             r_type_pos == TYPE_LENS[KW_STATUS]) begin
                    o_res.reply       = REPLY_NONE;
                    o_res.status_seen = 1'b1;
                    o_res.status_id   = r_id_value;
                end else begin
                    o_res.reply = REPLY_ERROR;
                end
            end else if (i_byte != CHAR_CR) begin
                if (r_line_count >= LCW'(MAX_LINE_CHARS)) begin
                    do_clear    = 1'b1;
                    o_res.reply = REPLY_ERROR;
                end else begin
                    n_line_count = r_line_count + LCW'(1);
                    if (is_ws) begin
                        if (r_content) begin
                            n_space = 1'b1;
                        end
                    end else begin
                        // content held back behind whitespace spoils the line
                        if (r_space) begin
                            n_badcs = 1'b1;
                        end
                        n_content = 1'b1;
                        if (!is_good) begin
                            n_badcs = 1'b1;
                        end else begin
                            case (r_field_phase)
                                PHASE_TYPE: begin
                                    if (i_byte == CHAR_COLON) begin
                                        n_field_phase = PHASE_ID;
                                    end else begin
                                        for (int k = 0; k < 4; k++) begin
                                            if (!type_char_hit(2'(k), r_type_pos, i_byte)) begin
                                                n_type_match[k] = 1'b0;
                                            end
                                        end
                                        if (r_type_pos != 3'd7) begin
                                            n_type_pos = r_type_pos + 3'd1;
                                        end
                                    end
                                end
                                PHASE_ID: begin
                                    if (i_byte == CHAR_COLON) begin
                                        n_field_phase = PHASE_PAYLOAD;
                                    end else begin
                                        if (is_digit) begin
                                            n_id_value = (r_id_value << 3) + (r_id_value << 1)
                                                       + {12'd0, i_byte[3:0]};
                                        end else begin
                                            n_id_bad = 1'b1;
                                        end
                                        n_id_empty = 1'b0;
                                    end
                                end
                                default: begin
                                    for (int k = 0; k < 2; k++) begin
                                        if (!pay_char_hit(1'(k), r_pay_pos, i_byte)) begin
                                            n_pay_match[k] = 1'b0;
                                        end
                                    end
                                    if (r_pay_pos < 4'd8) begin
                                        n_pay_pos = r_pay_pos + 4'd1;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
        end

        if (do_clear) begin
            n_line_count  = '0;
            n_field_phase = PHASE_TYPE;
            n_type_match  = 4'hF;
            n_type_pos    = 3'd0;
            n_pay_match   = 2'h3;
            n_pay_pos     = 4'd0;
            n_id_value    = 16'd0;
            n_id_empty    = 1'b1;
            n_id_bad      = 1'b0;
            n_content     = 1'b0;
            n_space       = 1'b0;
            n_badcs       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count  <= '0;
            r_field_phase <= PHASE_TYPE;
            r_type_match  <= 4'hF;
            r_type_pos    <= 3'd0;
            r_pay_match   <= 2'h3;
            r_pay_pos     <= 4'd0;
            r_id_value    <= 16'd0;
            r_id_empty    <= 1'b1;
            r_id_bad      <= 1'b0;
            r_content     <= 1'b0;
            r_space       <= 1'b0;
            r_badcs       <= 1'b0;
        end else begin
            r_line_count  <= n_line_count;
            r_field_phase <= n_field_phase;
            r_type_match  <= n_type_match;
            r_type_pos    <= n_type_pos;
            r_pay_match   <= n_pay_match;
            r_pay_pos     <= n_pay_pos;
            r_id_value    <= n_id_value;
            r_id_empty    <= n_id_empty;
            r_id_bad      <= n_id_bad;
            r_content     <= n_content;
            r_space       <= n_space;
            r_badcs       <= n_badcs;
        end
    end

endmodule

>>> design/tlcr_ack_tracker.sv
// tlcr_ack_tracker: own command id counter, pending command and its timeout
// matches STATUS lines from the parser; depends on tlcr_pkg

module tlcr_ack_tracker import tlcr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [1:0]  i_action,
    input  t_line_res   i_line,
    input  logic [15:0] i_timeout,
    output t_ack_res    o_res
);

    logic [15:0] r_pending_id, n_pending_id;
    logic [15:0] r_next_id, n_next_id;
    logic [15:0] r_timeout_left, n_timeout_left;

    always_comb begin
        n_pending_id   = r_pending_id;
        n_next_id      = r_next_id;
        n_timeout_left = r_timeout_left;
        o_res          = '0;

        if (i_en) begin
            if (i_line.status_seen && r_pending_id != 16'd0 &&
                i_line.status_id == r_pending_id) begin
                o_res.ack_event = ACK_DONE;
                o_res.ack_id    = r_pending_id;
                n_pending_id    = 16'd0;
            end
            case (i_action)
                ACT_TICK: begin
                    if (r_pending_id != 16'd0) begin
                        if (r_timeout_left <= 16'd1) begin
                            o_res.ack_event = ACK_TIMEOUT;
                            o_res.ack_id    = r_pending_id;
                            n_pending_id    = 16'd0;
                            n_timeout_left  = 16'd0;
                        end else begin
                            n_timeout_left = r_timeout_left - 16'd1;
                        end
                    end
                end
                ACT_ISSUE: begin
                    n_next_id        = r_next_id + 16'd1;
                    o_res.command_id = n_next_id;
                    n_pending_id     = n_next_id;
                    n_timeout_left   = i_timeout;
                    // zero timeout expires in the issuing transaction
                    if (n_next_id != 16'd0 && i_timeout == 16'd0) begin
                        o_res.ack_event = ACK_TIMEOUT;
                        o_res.ack_id    = n_next_id;
                        n_pending_id    = 16'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_id   <= 16'd0;
            r_next_id      <= 16'd0;
            r_timeout_left <= 16'd0;
        end else begin
            r_pending_id   <= n_pending_id;
            r_next_id      <= n_next_id;
            r_timeout_left <= n_timeout_left;
        end
    end

endmodule

>>> design/text_line_command_receiver_unit.sv
// text_line_command_receiver_unit: top level with input and result registers and config
// uses tlcr_pkg, tlcr_line_parser and tlcr_ack_tracker
//
// One transaction is taken per clock: a byte, a millisecond tick or an own command issue.
// Each one is held in an input register, decoded by short logic in the line parser and
// the acknowledgement tracker, and is then written into the result register; exactly one
// result follows every input transaction. The result register is the only thing that
// holds up the input side, so with the output taken every cycle the block sustains
// one transaction per cycle. Configuration writes take effect on the next transaction
// and there is no start-up pass after reset.

module text_line_command_receiver_unit import tlcr_pkg::*; #(
    parameter int MAX_LINE_CHARS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [15:0] r_ask_timeout;
    logic        r_led_active_high;
    logic        r_led_state, n_led_state;

    logic      advance;
    logic      byte_en;
    t_line_res line_res;
    t_ack_res  ack_res;
    t_out_item n_out_item;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign byte_en    = advance && (r_in_item.action == ACT_BYTE);

    tlcr_line_parser #(
        .MAX_LINE_CHARS(MAX_LINE_CHARS)
    ) u_parser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (byte_en),
        .i_byte (r_in_item.rx_byte),
        .o_res  (line_res)
    );

    tlcr_ack_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_action (r_in_item.action),
        .i_line   (line_res),
        .i_timeout(r_ask_timeout),
        .o_res    (ack_res)
    );

    always_comb begin
        n_led_state = r_led_state;
        if (advance && line_res.led_write) begin
            n_led_state = line_res.led_value;
        end
        n_out_item.reply      = line_res.reply;
        n_out_item.reply_id   = line_res.reply_id;
        n_out_item.led_level  = (n_led_state == r_led_active_high);
        n_out_item.ack_event  = ack_res.ack_event;
        n_out_item.ack_id     = ack_res.ack_id;
        n_out_item.command_id = ack_res.command_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_led_state       <= 1'b0;
            r_ask_timeout     <= 16'd1000;
            r_led_active_high <= 1'b1;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_led_state <= n_led_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ASK_TIMEOUT:     r_ask_timeout     <= i_cfg_data;
                    CFG_LED_ACTIVE_HIGH: r_led_active_high <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // input side stalls only behind a full, unaccepted result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    a_err_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.reply == REPLY_ERROR) |-> (o_out_item.reply_id == 16'd0))
        else $error("error reply carries an id");

    a_ack_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.ack_event == ACK_NONE) |-> (o_out_item.ack_id == 16'd0))
        else $error("ack id without ack event");

    a_issue_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.command_id != 16'd0) |->
            (o_out_item.reply == REPLY_NONE && o_out_item.ack_event != ACK_DONE))
        else $error("command issue mixed with line result");

endmodule

>>> sim/testbench.sv
// testbench: self-checking bench for text_line_command_receiver_unit
// drives text lines, ticks and own command issues, and predicts every result in step
// depends on tlcr_pkg and the design sources only

module testbench;
    import tlcr_pkg::*;

    localparam int         LINE_CAP = 64;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int         IDLE_PCT = 22;
    localparam int         REPORT_LIMIT = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    text_line_command_receiver_unit #(
        .MAX_LINE_CHARS(LINE_CAP)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // parser and tracker state as predicted
    int          line_len;
    logic [1:0]  phase_q;
    logic [3:0]  type_alive;
    int          type_pos;
    logic [1:0]  pay_alive;
    int          pay_pos;
    logic [15:0] id_acc;
    bit          id_empty;
    bit          id_bad;
    bit          has_content;
    bit          space_held;
    bit          bad_chars;
    logic [15:0] pending_cmd;
    logic [15:0] issued_id;
    logic [15:0] ticks_left;
    bit          led_on;
    logic [15:0] timeout_cfg;
    bit          active_high_cfg;

    t_out_item   expected_results[$];
    t_out_item   want;
    bit          quiet = 1'b0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          fail_count = 0;
    int          cfg_writes = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("text_line_command_receiver_unit test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // ---------------------------------------------------------------- predictor

    function automatic string type_word(int k);
        case (k)
            KW_PING: return "PING";
            KW_PONG: return "PONG";
            KW_CMD:  return "CMD";
            default: return "STATUS";
        endcase
    endfunction

    function automatic string pay_word(int k);
        return (k == PAY_LED_ON) ? "LED_ON" : "LED_OFF";
    endfunction

    function automatic bit word_hit(string w, int pos, logic [7:0] c);
        return (pos < w.len()) && (w[pos] == c);
    endfunction

    function automatic bit type_done(int k);
        return type_alive[k] && (type_pos == type_word(k).len());
    endfunction

    function automatic bit pay_done(int k);
        return pay_alive[k] && (pay_pos == pay_word(k).len());
    endfunction

    function automatic bit is_good_char(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
               c == CHAR_UNDER || c == CHAR_COLON;
    endfunction

    function automatic void clear_line();
        line_len = 0;
        phase_q = PHASE_TYPE;
        type_alive = 4'hF;
        type_pos = 0;
        pay_alive = 2'b11;
        pay_pos = 0;
        id_acc = '0;
        id_empty = 1'b1;
        id_bad = 1'b0;
        has_content = 1'b0;
        space_held = 1'b0;
        bad_chars = 1'b0;
    endfunction

    function automatic void reset_model();
        timeout_cfg = 16'd1000;
        active_high_cfg = 1'b1;
        clear_line();
        pending_cmd = '0;
        issued_id = '0;
        ticks_left = '0;
        led_on = 1'b0;
    endfunction

    function automatic void take_char(logic [7:0] c);
        if (space_held) bad_chars = 1'b1;
        has_content = 1'b1;
        if (!is_good_char(c)) begin
            bad_chars = 1'b1;
        end else if (phase_q == PHASE_TYPE) begin
            if (c == CHAR_COLON) begin
                phase_q = PHASE_ID;
            end else begin
                for (int k = 0; k < 4; k++)
                    if (!word_hit(type_word(k), type_pos, c)) type_alive[k] = 1'b0;
                if (type_pos < 7) type_pos++;
            end
        end else if (phase_q == PHASE_ID) begin
            if (c == CHAR_COLON) begin
                phase_q = PHASE_PAYLOAD;
            end else begin
                if (c >= "0" && c <= "9")
                    id_acc = id_acc * 16'd10 + 16'(c - "0");
                else
                    id_bad = 1'b1;
                id_empty = 1'b0;
            end
        end else begin
            for (int k = 0; k < 2; k++)
                if (!word_hit(pay_word(k), pay_pos, c)) pay_alive[k] = 1'b0;
            if (pay_pos < 8) pay_pos++;
        end
    endfunction

    function automatic void close_line(inout t_out_item r);
        if (!has_content) return;
        if (bad_chars) begin
            r.reply = REPLY_ERROR;
            return;
        end
        if (phase_q == PHASE_TYPE) begin
            if (type_done(KW_PING))
                r.reply = REPLY_PONG;
            else if (!type_done(KW_PONG))
                r.reply = REPLY_ERROR;
            return;
        end
        if (phase_q == PHASE_ID || id_empty || id_bad) begin
            r.reply = REPLY_ERROR;
            return;
        end
        if (type_done(KW_CMD)) begin
            r.reply_id = id_acc;
            if (pay_done(PAY_LED_ON)) begin
                led_on = 1'b1;
                r.reply = REPLY_OK;
            end else if (pay_done(PAY_LED_OFF)) begin
                led_on = 1'b0;
                r.reply = REPLY_OK;
            end else begin
                r.reply = REPLY_UNKNOWN;
            end
        end else if (type_done(KW_STATUS)) begin
            if (pending_cmd != 0 && id_acc == pending_cmd) begin
                r.ack_event = ACK_DONE;
                r.ack_id = id_acc;
                pending_cmd = '0;
            end
        end else begin
            r.reply = REPLY_ERROR;
        end
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        logic [7:0] c;
        r = '0;
        c = it.rx_byte;
        case (it.action)
            ACT_BYTE: begin
                if (c == CHAR_LF) begin
                    close_line(r);
                    clear_line();
                end else if (c != CHAR_CR) begin
                    if (line_len >= LINE_CAP) begin
                        clear_line();
                        r.reply = REPLY_ERROR;
                    end else begin
                        line_len++;
                        if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF) begin
                            if (has_content) space_held = 1'b1;
                        end else begin
                            take_char(c);
                        end
                    end
                end
            end
            ACT_TICK: begin
                if (pending_cmd != 0) begin
                    if (ticks_left <= 1) begin
                        r.ack_event = ACK_TIMEOUT;
                        r.ack_id = pending_cmd;
                        pending_cmd = '0;
                        ticks_left = '0;
                    end else begin
                        ticks_left--;
                    end
                end
            end
            ACT_ISSUE: begin
                issued_id++;
                r.command_id = issued_id;
                pending_cmd = issued_id;
                ticks_left = timeout_cfg;
                if (pending_cmd != 0 && ticks_left == 0) begin
                    r.ack_event = ACK_TIMEOUT;
                    r.ack_id = pending_cmd;
                    pending_cmd = '0;
                end
            end
            default: ;
        endcase
        r.led_level = (led_on == active_high_cfg);
        return r;
    endfunction

    // ---------------------------------------------------------------- result check

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: reply %0d id %0d ack %0d/%0d cmd %0d",
                             o_out_item.reply, o_out_item.reply_id, o_out_item.ack_event,
                             o_out_item.ack_id, o_out_item.command_id);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_out_item.reply !== want.reply || o_out_item.reply_id !== want.reply_id ||
                    o_out_item.led_level !== want.led_level ||
                    o_out_item.ack_event !== want.ack_event ||
                    o_out_item.ack_id !== want.ack_id ||
                    o_out_item.command_id !== want.command_id) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"result %0d mismatch: expected reply %0d id %0d led %0d ",
                                  "ack %0d/%0d cmd %0d, got reply %0d id %0d led %0d ",
                                  "ack %0d/%0d cmd %0d"},
                                 results_checked, want.reply, want.reply_id, want.led_level,
                                 want.ack_event, want.ack_id, want.command_id,
                                 o_out_item.reply, o_out_item.reply_id, o_out_item.led_level,
                                 o_out_item.ack_event, o_out_item.ack_id, o_out_item.command_id);
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_item(input logic [1:0] act, input logic [7:0] b);
        t_in_item it;
        it.action = act;
        it.rx_byte = b;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        expected_results.push_back(predict_result(it));
        items_sent++;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(ACT_BYTE, s[i]);
    endtask

    task automatic send_blanks(input int n);
        repeat (n) begin
            case ($urandom_range(3))
                0: send_item(ACT_BYTE, CHAR_SPACE);
                1: send_item(ACT_BYTE, CHAR_TAB);
                2: send_item(ACT_BYTE, CHAR_VT);
                default: send_item(ACT_BYTE, CHAR_FF);
            endcase
        end
    endtask

    task automatic send_good_chars(input int n);
        string pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_:";
        repeat (n) send_item(ACT_BYTE, pool[$urandom_range(pool.len() - 1)]);
    endtask

    // waits for the block to go idle, then writes one register
    task automatic write_reg(input logic idx, input logic [15:0] v);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ASK_TIMEOUT)
            timeout_cfg = v;
        else
            active_high_cfg = v[0];
        cfg_writes++;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_line_syntax();
        send_text("PING\n");
        send_text("PONG\n");
        send_text("CMD:12:LED_ON\n");
        send_item(ACT_BYTE, CHAR_VT);
        send_item(ACT_BYTE, CHAR_FF);
        send_text(" \tCMD:65537:LED_OFF \r\n");
        send_text("CMD:7:LED_ONN\n");
        send_text("CMD:00:A:B\n");
        send_text("   \n");
        send_text("Ping\n");
        send_text("CMD :1:LED_ON\n");
        send_text("CMD:5\n");
        send_text("CMD::LED_ON\n");
        send_text("CMD:1A:LED_ON\n");
        send_text("PONGS:1:X\n");
        send_text("STATUS:3:OK\n");
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, CHAR_LF);
        send_item(ACT_NONE, 8'hA5);
        send_item(ACT_TICK, 8'h5A);
    endtask

    task automatic test_overflow();
        // exactly full line still parses
        repeat (LINE_CAP - 4) send_item(ACT_BYTE, CHAR_SPACE);
        send_text("PING\n");
        // one byte too many, the remainder starts a new line
        repeat (LINE_CAP) send_item(ACT_BYTE, "A");
        send_text("PING\n");
        repeat (LINE_CAP) send_item(ACT_BYTE, "B");
        send_text("\r\n");
    endtask

    task automatic test_own_commands();
        logic [15:0] old_id;
        write_reg(CFG_ASK_TIMEOUT, 16'd2);
        send_item(ACT_ISSUE, 8'h00);
        repeat (3) send_item(ACT_TICK, 8'h00);
        send_item(ACT_ISSUE, 8'h00);
        send_text($sformatf("STATUS:%0d:DONE\n", pending_cmd + 65536));
        send_item(ACT_ISSUE, 8'h00);
        old_id = pending_cmd;
        send_item(ACT_ISSUE, 8'h00);
        send_text($sformatf("STATUS:%0d:X\n", old_id));
        send_text($sformatf("STATUS:%0d:X\n", pending_cmd));
        write_reg(CFG_ASK_TIMEOUT, 16'd0);
        send_item(ACT_ISSUE, 8'h00);
        write_reg(CFG_ASK_TIMEOUT, 16'hFFFF);
        send_item(ACT_ISSUE, 8'h00);
        repeat (3) send_item(ACT_TICK, 8'h00);
        send_text($sformatf("STATUS:%0d:\n", pending_cmd));
        write_reg(CFG_LED_ACTIVE_HIGH, 16'd0);
        send_text("CMD:1:LED_ON\n");
        send_text("CMD:2:LED_OFF\n");
        write_reg(CFG_LED_ACTIVE_HIGH, 16'd1);
        send_text("CMD:3:LED_ON\n");
    endtask

    task automatic send_random_line();
        int kind;
        int pick;
        send_blanks($urandom_range(2));
        kind = $urandom_range(99);
        if (kind < 8) begin
            send_text("PING");
        end else if (kind < 12) begin
            send_text("PONG");
        end else begin
            if (kind < 50) send_text("CMD");
            else if (kind < 85) send_text("STATUS");
            else if (kind < 92) send_text("CM");
            else send_good_chars($urandom_range(1, 5));
            if ($urandom_range(99) >= 4) send_text(":");
            pick = $urandom_range(99);
            if (pick < 40) send_text($sformatf("%0d", $urandom_range(99)));
            else if (pick < 70)
                send_text($sformatf("%0d", pending_cmd + ($urandom_range(1) ? 65536 : 0)));
            else if (pick < 90) send_text($sformatf("%0d", $urandom_range(9999999)));
            else if (pick >= 95) send_text("1X2");
            if ($urandom_range(99) >= 4) send_text(":");
            pick = $urandom_range(99);
            if (pick < 35) send_text("LED_ON");
            else if (pick < 65) send_text("LED_OFF");
            else if (pick < 75) send_text("LED_O");
            else if (pick < 82) send_text("LED_OFFX");
            else if (pick >= 90) send_good_chars($urandom_range(1, 8));
        end
        if ($urandom_range(99) < 6) send_item(ACT_BYTE, 8'($urandom_range(255)));
        send_blanks($urandom_range(2));
        if ($urandom_range(99) < 30) send_item(ACT_BYTE, CHAR_CR);
        send_item(ACT_BYTE, CHAR_LF);
    endtask

    task automatic test_random_traffic();
        logic [15:0] tmo;
        int stop_at;
        int pick;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: tmo = 16'd0;
                1: tmo = 16'd1;
                2: tmo = 16'hFFFF;
                3: tmo = 16'd3;
                default: tmo = 16'($urandom_range(2, 40));
            endcase
            write_reg(CFG_ASK_TIMEOUT, tmo);
            write_reg(CFG_LED_ACTIVE_HIGH, {15'd0, phase[0]});
            quiet = (phase == 2);
            stop_at = items_sent + 50;
            while (items_sent < stop_at) begin
                pick = $urandom_range(99);
                if (pick < 65)
                    send_random_line();
                else if (pick < 80)
                    repeat ($urandom_range(1, 4))
                        send_item(ACT_TICK, 8'($urandom_range(255)));
                else if (pick < 88)
                    send_item(ACT_ISSUE, 8'($urandom_range(255)));
                else if (pick < 97)
                    repeat ($urandom_range(1, 8))
                        send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
                else
                    send_good_chars($urandom_range(60, 80));
            end
        end
        quiet = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_line_syntax();
        test_overflow();
        test_own_commands();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("sent %0d transactions over %0d register writes", items_sent, cfg_writes);
        $display("checked %0d results, %0d failures", results_checked, fail_count);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("text_line_command_receiver_unit test passed");
        else
            $display("text_line_command_receiver_unit test failed");
        $finish;
    end

endmodule

>>> sim.f
design/tlcr_pkg.sv
design/tlcr_line_parser.sv
design/tlcr_ack_tracker.sv
design/text_line_command_receiver_unit.sv
sim/testbench.sv
